### rtl/teeq_pkg.sv
// Shared constants and types for the touch edge event queue.
package teeq_pkg;

   // Field widths of the request and response words.
   localparam int MASK_W          = 12;
   localparam int CODE_W          = 8;
   localparam int SLOT_W          = 5;
   localparam int PENDING_W       = 5;

   // Defaults for the top-level parameters.
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int PADS_DEF        = 12;

   // Key map layout: second sensor pad i reads entry i plus this offset.
   localparam int MAP_ENTRIES     = 20;
   localparam int SECOND_OFFSET   = 8;
   localparam logic [CODE_W-1:0] UNMAPPED = 8'hFF;

   // Request action codes.
   typedef enum logic [1:0] {
      ACT_PRIME = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_POP   = 2'd2,
      ACT_MAP   = 2'd3
   } teeq_action_type;

   // One queued key event.
   typedef struct packed {
      logic              released;
      logic [CODE_W-1:0] code;
   } teeq_event_type;

   localparam int EVENT_W = $bits(teeq_event_type);

   // What one pad lane found on a tick.
   typedef struct packed {
      logic           hit;
      teeq_event_type ev;
   } teeq_lane_out_type;

   // Output of the merging stage toward the queue.
   typedef struct packed {
      logic           push;
      teeq_event_type ev;
   } teeq_merge_out_type;

   // Command to the event queue.
   typedef struct packed {
      logic           push;
      logic           pop;
      teeq_event_type push_ev;
   } teeq_qcmd_type;

endpackage

### rtl/teeq_if.sv
// Request and response channel interfaces of the touch edge event queue.
interface teeq_req_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       action;
   logic [teeq_pkg::MASK_W-1:0]      mask_first;
   logic [teeq_pkg::MASK_W-1:0]      mask_second;
   logic [teeq_pkg::SLOT_W-1:0]      map_slot;
   logic [teeq_pkg::CODE_W-1:0]      map_code;

   modport source (output valid, action, mask_first, mask_second, map_slot, map_code,
                   input ready);
   modport sink   (input valid, action, mask_first, mask_second, map_slot, map_code,
                   output ready);
endinterface

interface teeq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             event_valid;
   logic [teeq_pkg::CODE_W-1:0]      key_code;
   logic                             released;
   logic [teeq_pkg::PENDING_W-1:0]   pending;
   logic                             empty_pop;

   modport source (output valid, event_valid, key_code, released, pending, empty_pop,
                   input ready);
   modport sink   (input valid, event_valid, key_code, released, pending, empty_pop,
                   output ready);
endinterface

### rtl/teeq_lane.sv
// One pad lane: edge detection of a single touch bit against its mapped key.
module teeq_lane (
   input  logic                          now_bit,
   input  logic                          before_bit,
   input  logic [teeq_pkg::CODE_W-1:0]   code,
   output teeq_pkg::teeq_lane_out_type   result
);
   import teeq_pkg::*;

   // A mapped pad whose bit changed gives a press on a rise and a release on a fall.
   always_comb begin
      result.hit         = (code != UNMAPPED) && (now_bit != before_bit);
      result.ev.released = before_bit & ~now_bit;
      result.ev.code     = code;
   end

endmodule

### rtl/teeq_merge.sv
// Merging stage: hands the lane events to the queue one per cycle, lowest lane first.
module teeq_merge #(
   parameter int LANES = 2 * teeq_pkg::PADS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  teeq_pkg::teeq_lane_out_type   lane_res [LANES],
   output teeq_pkg::teeq_merge_out_type  mout
);
   import teeq_pkg::*;

   logic [LANES-1:0]   pend_ff;
   logic [LANES-1:0]   pend_in;
   teeq_event_type     ev_ff [LANES];
   logic [LANES-1:0]   pick;
   logic [EVENT_W-1:0] sel_bits;

   // Isolate the lowest pending lane and select its event.
   always_comb begin
      pick     = pend_ff & (~pend_ff + LANES'(1));
      sel_bits = '0;
      for (int i = 0; i < LANES; i++) begin
         if (pick[i]) begin
            sel_bits = sel_bits | ev_ff[i];
         end
      end
      mout.push = |pend_ff;
      mout.ev   = teeq_event_type'(sel_bits);
   end

   // Load all lane hits on a tick, then retire one per cycle.
   always_comb begin
      pend_in = pend_ff & ~pick;
      if (load) begin
         for (int i = 0; i < LANES; i++) begin
            pend_in[i] = lane_res[i].hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   // Event words need no reset; they are only read under a pending bit.
   always_ff @(posedge clock) begin
      if (load) begin
         for (int i = 0; i < LANES; i++) begin
            ev_ff[i] <= lane_res[i].ev;
         end
      end
   end

endmodule

### rtl/teeq_queue.sv
// Ring queue of key events that overwrites the oldest entry when full.
module teeq_queue #(
   parameter int DEPTH = teeq_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  teeq_pkg::teeq_qcmd_type        cmd,
   output teeq_pkg::teeq_event_type       rd_data,
   output logic [$clog2(DEPTH+1)-1:0]     held_count
);
   import teeq_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   teeq_event_type   event_store_ff [DEPTH];
   teeq_event_type   rd_data_ff;
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] held_ff;
   logic [PTR_W-1:0] wr_ptr_next;
   logic [PTR_W-1:0] rd_ptr_next;
   logic             full;

   // Pointer increments wrap at the queue depth.
   always_comb begin
      wr_ptr_next = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      rd_ptr_next = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      full        = (held_ff == CNT_W'(DEPTH));
   end

   // Pointer and count bookkeeping; a push into a full queue drops the oldest word.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         held_ff   <= '0;
      end else if (cmd.push) begin
         wr_ptr_ff <= wr_ptr_next;
         if (full) begin
            rd_ptr_ff <= rd_ptr_next;
         end else begin
            held_ff <= held_ff + CNT_W'(1);
         end
      end else if (cmd.pop) begin
         rd_ptr_ff <= rd_ptr_next;
         held_ff   <= held_ff - CNT_W'(1);
      end
   end

   // Event memory with one write port and a registered read port.
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         event_store_ff[wr_ptr_ff] <= cmd.push_ev;
      end
      if (cmd.pop) begin
         rd_data_ff <= event_store_ff[rd_ptr_ff];
      end
   end

   assign rd_data    = rd_data_ff;
   assign held_count = held_ff;

endmodule

### rtl/touch_edge_event_queue_core.sv
// Top level of the touch edge event queue: key map, pad lanes, merger and event queue.
// Prime, pop and map writes go from the idle state to the done state, which loads the response
// register once it is free. A tick first passes through the scan state until the merger has queued
// its events (at most 2 * PADS_PER_SENSOR); the merger feeds the queue one event per cycle.
// One request word is worked at a time; the next is taken while the last response waits.
// Reset: previous masks zero, key map all unmapped, queue empty; event memory not cleared.
module touch_edge_event_queue_core #(
   parameter int QUEUE_DEPTH     = teeq_pkg::QUEUE_DEPTH_DEF,
   parameter int PADS_PER_SENSOR = teeq_pkg::PADS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   teeq_req_if.sink    req_chan,
   teeq_rsp_if.source  rsp_chan
);
   import teeq_pkg::*;

   localparam int LANES = 2 * PADS_PER_SENSOR;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type          state_ff;
   logic [MASK_W-1:0]  prev_first_ff;
   logic [MASK_W-1:0]  prev_second_ff;
   logic [CODE_W-1:0]  key_map_ff [MAP_ENTRIES];
   logic               pop_hit_ff;
   logic               empty_ff;
   logic               rsp_valid_ff;
   logic               rsp_event_valid_ff;
   logic [CODE_W-1:0]  rsp_key_code_ff;
   logic               rsp_released_ff;
   logic [PENDING_W-1:0] rsp_pending_ff;
   logic               rsp_empty_pop_ff;

   logic               accept;
   logic               rsp_free;
   teeq_action_type    action;
   teeq_lane_out_type  lane_res [LANES];
   teeq_merge_out_type mout;
   teeq_qcmd_type      qcmd;
   teeq_event_type     rd_data;
   logic [CNT_W-1:0]   held_count;

   // Handshake decode.
   always_comb begin
      action   = teeq_action_type'(req_chan.action);
      accept   = req_chan.valid && (state_ff == ST_IDLE);
      rsp_free = !rsp_valid_ff || rsp_chan.ready;
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   // Pad lanes compare the incoming masks with the previous ones.
   for (genvar i = 0; i < PADS_PER_SENSOR; i++) begin : g_pad
      teeq_lane u_lane_first (
         .now_bit    (req_chan.mask_first[i]),
         .before_bit (prev_first_ff[i]),
         .code       (key_map_ff[i]),
         .result     (lane_res[i])
      );
      teeq_lane u_lane_second (
         .now_bit    (req_chan.mask_second[i]),
         .before_bit (prev_second_ff[i]),
         .code       (key_map_ff[i + SECOND_OFFSET]),
         .result     (lane_res[i + PADS_PER_SENSOR])
      );
   end

   teeq_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .load     (accept && (action == ACT_TICK)),
      .lane_res (lane_res),
      .mout     (mout)
   );

   // Queue commands: pushes come from the merger, pops from a request word.
   always_comb begin
      qcmd.push    = (state_ff == ST_SCAN) && mout.push;
      qcmd.push_ev = mout.ev;
      qcmd.pop     = accept && (action == ACT_POP) && (held_count != '0);
   end

   teeq_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .cmd        (qcmd),
      .rd_data    (rd_data),
      .held_count (held_count)
   );

   // Sequencer, key map, previous masks and response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         prev_first_ff  <= '0;
         prev_second_ff <= '0;
         for (int i = 0; i < MAP_ENTRIES; i++) begin
            key_map_ff[i] <= UNMAPPED;
         end
         pop_hit_ff     <= 1'b0;
         empty_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // A taken response clears, unless a new one is loaded in the same cycle.
         if (rsp_chan.ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pop_hit_ff <= (action == ACT_POP) && (held_count != '0);
                  empty_ff   <= (action == ACT_POP) && (held_count == '0);
                  state_ff   <= (action == ACT_TICK) ? ST_SCAN : ST_DONE;
                  unique case (action)
                     ACT_PRIME: begin
                        prev_first_ff  <= req_chan.mask_first;
                        prev_second_ff <= req_chan.mask_second;
                     end
                     ACT_TICK: begin
                        prev_first_ff  <= req_chan.mask_first;
                        prev_second_ff <= req_chan.mask_second;
                     end
                     ACT_POP: begin
                     end
                     ACT_MAP: begin
                        if (req_chan.map_slot < SLOT_W'(MAP_ENTRIES)) begin
                           key_map_ff[req_chan.map_slot] <= req_chan.map_code;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               if (!mout.push) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_event_valid_ff <= pop_hit_ff;
                  rsp_key_code_ff    <= pop_hit_ff ? rd_data.code : '0;
                  rsp_released_ff    <= pop_hit_ff & rd_data.released;
                  rsp_pending_ff     <= PENDING_W'(held_count);
                  rsp_empty_pop_ff   <= empty_ff;
                  state_ff           <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Response word.
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.event_valid = rsp_event_valid_ff;
   assign rsp_chan.key_code    = rsp_key_code_ff;
   assign rsp_chan.released    = rsp_released_ff;
   assign rsp_chan.pending     = rsp_pending_ff;
   assign rsp_chan.empty_pop   = rsp_empty_pop_ff;

endmodule

### tb/sv/teeq_event_checker.sv
// Checker for the touch edge event queue: tracks accepted words, predicts replies, compares.
module teeq_event_checker (
   input  logic   clock,
   input  logic   reset,
   teeq_req_if    req_chan,
   teeq_rsp_if    rsp_chan,
   output int     fail_count,
   output int     words_owed
);
   import teeq_pkg::*;

   localparam int DEPTH = QUEUE_DEPTH_DEF;
   localparam int PADS  = PADS_DEF;

   // One reply word as the block should give it.
   typedef struct packed {
      logic                 event_valid;
      logic [CODE_W-1:0]    key_code;
      logic                 released;
      logic [PENDING_W-1:0] pending;
      logic                 empty_pop;
   } reply_word_type;

   // Shadow state of the keypad front end.
   logic [MASK_W-1:0] last_first;
   logic [MASK_W-1:0] last_second;
   logic [CODE_W-1:0] code_map [MAP_ENTRIES];
   teeq_event_type    held_events [$];
   reply_word_type    owed_replies [$];
   int                failures;

   // Append one key event; a full ring drops its oldest entry.
   function automatic void queue_key_event(input logic rel, input logic [CODE_W-1:0] key);
      teeq_event_type ev;
      ev.released = rel;
      ev.code     = key;
      held_events.push_back(ev);
      if (held_events.size() > DEPTH) void'(held_events.pop_front());
   endfunction

   // Compare one sensor's mask with its previous value, pad 0 upward, press before release.
   function automatic void scan_pads(input logic [MASK_W-1:0] now_mask,
                                     input logic [MASK_W-1:0] old_mask, input int offset);
      int                entry;
      logic [CODE_W-1:0] key;
      for (int pad = 0; pad < PADS && pad < MASK_W; pad++) begin
         entry = pad + offset;
         key   = (entry < MAP_ENTRIES) ? code_map[entry] : UNMAPPED;
         if (key != UNMAPPED) begin
            if (now_mask[pad] && !old_mask[pad]) queue_key_event(1'b0, key);
            if (!now_mask[pad] && old_mask[pad]) queue_key_event(1'b1, key);
         end
      end
   endfunction

   // Apply one request word to the shadow state and return the reply it earns.
   function automatic reply_word_type predict_reply(input teeq_action_type act,
                                                    input logic [MASK_W-1:0] now_first,
                                                    input logic [MASK_W-1:0] now_second,
                                                    input logic [SLOT_W-1:0] slot,
                                                    input logic [CODE_W-1:0] key);
      reply_word_type reply;
      teeq_event_type ev;
      reply = '0;
      case (act)
         ACT_PRIME: begin
            last_first  = now_first;
            last_second = now_second;
         end
         ACT_TICK: begin
            scan_pads(now_first, last_first, 0);
            last_first = now_first;
            scan_pads(now_second, last_second, SECOND_OFFSET);
            last_second = now_second;
         end
         ACT_POP: begin
            if (held_events.size() == 0) begin
               reply.empty_pop = 1'b1;
            end else begin
               ev                = held_events.pop_front();
               reply.event_valid = 1'b1;
               reply.key_code    = ev.code;
               reply.released    = ev.released;
            end
         end
         default: begin
            // Slots past the end of the map are dropped.
            if (slot < MAP_ENTRIES) code_map[slot] = key;
         end
      endcase
      reply.pending = PENDING_W'(held_events.size());
      return reply;
   endfunction

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endfunction

   // Watch both channels at every rising edge.
   always @(posedge clock) begin
      reply_word_type want;
      if (reset) begin
         last_first  = '0;
         last_second = '0;
         for (int i = 0; i < MAP_ENTRIES; i++) code_map[i] = UNMAPPED;
         held_events.delete();
         owed_replies.delete();
         failures = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (owed_replies.size() == 0) begin
               $error("reply word arrived with no request word outstanding");
               failures++;
            end else begin
               want = owed_replies.pop_front();
               check_field("event_valid", want.event_valid, rsp_chan.event_valid);
               check_field("key_code", want.key_code, rsp_chan.key_code);
               check_field("released", want.released, rsp_chan.released);
               check_field("pending", want.pending, rsp_chan.pending);
               check_field("empty_pop", want.empty_pop, rsp_chan.empty_pop);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            owed_replies.push_back(predict_reply(teeq_action_type'(req_chan.action),
                                                 req_chan.mask_first, req_chan.mask_second,
                                                 req_chan.map_slot, req_chan.map_code));
         end
      end
      fail_count <= failures;
      words_owed <= owed_replies.size();
   end

endmodule

### tb/sv/testbench.sv
// Top of the touch edge event queue testbench: clock, reset, stimulus and verdict.
module testbench;
   import teeq_pkg::*;

   localparam int RANDOM_WORDS = 1650;
   localparam int CYCLE_LIMIT  = 1000000;

   logic clock;
   logic reset;
   int   fail_count;
   int   words_owed;
   int   cycle_count;
   bit   send_gaps_on;
   bit   stall_on;
   logic [MASK_W-1:0] drive_first;
   logic [MASK_W-1:0] drive_second;

   teeq_req_if req_chan ();
   teeq_rsp_if rsp_chan ();

   touch_edge_event_queue_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   teeq_event_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .fail_count (fail_count),
      .words_owed (words_owed)
   );

   // Twelve-unit clock, low first.
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Mostly short pauses, now and then a long one.
   function automatic int idle_length(input bit enabled);
      int roll;
      roll = $urandom_range(0, 99);
      if (!enabled || roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Flip a random pad of a mask one to three times; a pad may be picked more than once.
   function automatic logic [MASK_W-1:0] nudge_mask(input logic [MASK_W-1:0] mask);
      logic [MASK_W-1:0] result;
      result = mask;
      repeat ($urandom_range(1, 3)) result[$urandom_range(0, MASK_W - 1)] ^= 1'b1;
      return result;
   endfunction

   function automatic logic [MASK_W-1:0] pick_mask(input logic [MASK_W-1:0] mask);
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return nudge_mask(mask);
      if (roll < 9) return MASK_W'($urandom);
      return (roll[0]) ? '1 : '0;
   endfunction

   // Offer one request word after an optional pause and wait until it is taken.
   task automatic send_word(input teeq_action_type act, input logic [MASK_W-1:0] m_first,
                            input logic [MASK_W-1:0] m_second, input logic [SLOT_W-1:0] slot,
                            input logic [CODE_W-1:0] key);
      int gap;
      gap = idle_length(send_gaps_on);
      repeat (gap) begin
         @(negedge clock);
         req_chan.valid <= 1'b0;
      end
      @(negedge clock);
      req_chan.valid       <= 1'b1;
      req_chan.action      <= act;
      req_chan.mask_first  <= m_first;
      req_chan.mask_second <= m_second;
      req_chan.map_slot    <= slot;
      req_chan.map_code    <= key;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Reply side back-pressure, switched on and off in stretches.
   initial begin
      int stall_left;
      int stretch;
      rsp_chan.ready <= 1'b0;
      stall_left = 0;
      stretch    = 0;
      forever begin
         @(negedge clock);
         if (stretch == 0) begin
            stretch  = $urandom_range(64, 256);
            stall_on = ($urandom_range(0, 3) != 0);
         end
         stretch--;
         if (stall_left == 0) stall_left = idle_length(stall_on);
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int pop_share;
      int roll;
      logic [SLOT_W-1:0] slot;
      logic [CODE_W-1:0] key;
      cycle_count          = 0;
      send_gaps_on         = 1'b1;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.action     <= ACT_PRIME;
      req_chan.mask_first <= '0;
      req_chan.mask_second <= '0;
      req_chan.map_slot   <= '0;
      req_chan.map_code   <= '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty pop, ticks on an unmapped map, map extremes and shared entries,
      // ignored slots, an unmapping code, priming, and flips that overflow the ring.
      send_word(ACT_POP, '0, '0, '0, '0);
      send_word(ACT_TICK, '1, '1, '0, '0);
      send_word(ACT_MAP, '0, '0, 5'd0, 8'd0);
      send_word(ACT_MAP, '0, '0, 5'd19, 8'd254);
      send_word(ACT_MAP, '0, '0, SLOT_W'(SECOND_OFFSET), 8'h5A);
      send_word(ACT_MAP, '0, '0, 5'd20, 8'd7);
      send_word(ACT_MAP, '0, '0, 5'd31, 8'd9);
      send_word(ACT_MAP, '0, '0, 5'd3, UNMAPPED);
      send_word(ACT_TICK, '0, '0, '0, '0);
      send_word(ACT_PRIME, '1, '0, '0, '0);
      send_word(ACT_TICK, '0, '1, '0, '0);
      send_word(ACT_TICK, '1, '0, '0, '0);
      send_word(ACT_TICK, '0, '1, '0, '0);
      send_word(ACT_TICK, '1, '0, '0, '0);
      repeat (3) send_word(ACT_POP, '0, '0, '0, '0);
      send_word(ACT_MAP, '0, '0, 5'd0, UNMAPPED);
      send_word(ACT_TICK, '0, '1, '0, '0);
      drive_first  = '0;
      drive_second = '1;

      // Random: phases that lean toward filling or draining the ring.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 100 == 0) begin
            send_gaps_on = ($urandom_range(0, 3) != 0);
            roll         = $urandom_range(0, 2);
            pop_share    = (roll == 0) ? 20 : (roll == 1) ? 45 : 70;
         end
         slot = ($urandom_range(0, 99) < 85) ? SLOT_W'($urandom_range(0, MAP_ENTRIES - 1))
                                             : SLOT_W'($urandom_range(MAP_ENTRIES, 31));
         key  = ($urandom_range(0, 9) == 0) ? UNMAPPED : CODE_W'($urandom_range(0, 254));
         if ($urandom_range(0, 99) < pop_share) begin
            send_word(ACT_POP, MASK_W'($urandom), MASK_W'($urandom), slot, key);
         end else begin
            roll = $urandom_range(0, 19);
            if (roll < 13) begin
               drive_first  = pick_mask(drive_first);
               drive_second = pick_mask(drive_second);
               send_word(ACT_TICK, drive_first, drive_second, slot, key);
            end else if (roll < 17) begin
               send_word(ACT_MAP, MASK_W'($urandom), MASK_W'($urandom), slot, key);
            end else begin
               drive_first  = pick_mask(drive_first);
               drive_second = pick_mask(drive_second);
               send_word(ACT_PRIME, drive_first, drive_second, slot, key);
            end
         end
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      // Drain, then allow for the longest tick before the verdict.
      while (words_owed != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
